[rtl/hbrp_pkg.sv]
// Shared types, phase codes and helpers for the byte-range header parser.
package hbrp_pkg;

    localparam int unsigned NUM_W  = 64;
    localparam int unsigned SIZE_W = 63;

    // Parse phases
    localparam logic [2:0] PH_PREFIX = 3'd0;
    localparam logic [2:0] PH_LEAD   = 3'd1;
    localparam logic [2:0] PH_FIRST  = 3'd2;
    localparam logic [2:0] PH_DASH   = 3'd3;
    localparam logic [2:0] PH_WS2    = 3'd4;
    localparam logic [2:0] PH_NUM2   = 3'd5;
    localparam logic [2:0] PH_TRAIL  = 3'd6;

    localparam logic [2:0] PREFIX_LAST = 3'd5;
    localparam logic [7:0] CHAR_EQ     = 8'h3D;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CASE_BIT    = 8'h20;

    typedef struct packed {
        logic [2:0]       phase;
        logic [2:0]       pos;
        logic [NUM_W-1:0] first_num;
        logic [NUM_W-1:0] second_num;
        logic             first_seen;
        logic             second_seen;
        logic             ovf;
        logic             err;
    } parse_state_t;

    localparam parse_state_t PARSE_CLEAR = '{default: '0};

    typedef struct packed {
        logic              status;
        logic [SIZE_W-1:0] start_ofs;
        logic [SIZE_W-1:0] end_ofs;
    } range_result_t;

    // Expected prefix character, lower case
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h62; // b
            3'd1:    ch = 8'h79; // y
            3'd2:    ch = 8'h74; // t
            3'd3:    ch = 8'h65; // e
            3'd4:    ch = 8'h73; // s
            default: ch = CHAR_EQ;
        endcase
        return ch;
    endfunction

endpackage

[rtl/hbrp_parse.sv]
// Per-beat parse state machine: prefix match, phases and decimal accumulate.
module hbrp_parse
    import hbrp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         beat_en,
    input  logic [7:0]   value_byte,
    input  logic         last_byte,
    output logic         snap_load,
    output parse_state_t snap
);

    parse_state_t st_reg;
    parse_state_t st_next;

    logic             is_ws;
    logic             is_digit;
    logic             pre_match;
    logic [7:0]       want;
    logic [NUM_W-1:0] acc_in;
    logic [NUM_W+3:0] acc_sum;
    logic             acc_ovf;
    logic [NUM_W-1:0] acc_val;

    always_comb begin
        is_ws    = (value_byte == 8'h20) || (value_byte inside {[8'h09:8'h0D]});
        is_digit = value_byte inside {[8'h30:8'h39]};
        want     = prefix_char(st_reg.pos);
        pre_match = (want == CHAR_EQ) ? (value_byte == want)
                                      : ((value_byte | CASE_BIT) == want);
        // n*10 + d as (n<<3) + (n<<1) + d
        acc_in  = ((st_reg.phase == PH_LEAD) || (st_reg.phase == PH_FIRST))
                  ? st_reg.first_num : st_reg.second_num;
        acc_sum = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0}
                  + {{NUM_W{1'b0}}, value_byte[3:0]};
        acc_ovf = |acc_sum[NUM_W+3:NUM_W];
        acc_val = acc_ovf ? {NUM_W{1'b1}} : acc_sum[NUM_W-1:0];
    end

    always_comb begin
        st_next = st_reg;
        if (!st_reg.err) begin
            case (st_reg.phase)
                PH_PREFIX: begin
                    if (!pre_match) begin
                        st_next.err = 1'b1;
                    end else if (st_reg.pos >= PREFIX_LAST) begin
                        st_next.phase = PH_LEAD;
                    end else begin
                        st_next.pos = st_reg.pos + 3'd1;
                    end
                end
                PH_LEAD: begin
                    if (is_ws) begin
                        st_next.phase = PH_LEAD;
                    end else if (value_byte == CHAR_DASH) begin
                        st_next.phase = PH_DASH;
                    end else if (is_digit) begin
                        st_next.first_num  = acc_val;
                        st_next.ovf        = st_reg.ovf | acc_ovf;
                        st_next.first_seen = 1'b1;
                        st_next.phase      = PH_FIRST;
                    end else begin
                        st_next.err = 1'b1;
                    end
                end
                PH_FIRST: begin
                    if (is_digit) begin
                        st_next.first_num = acc_val;
                        st_next.ovf       = st_reg.ovf | acc_ovf;
                    end else if (value_byte == CHAR_DASH) begin
                        st_next.phase = PH_DASH;
                    end else begin
                        st_next.err = 1'b1;
                    end
                end
                PH_DASH, PH_WS2: begin
                    if (is_ws) begin
                        st_next.phase = PH_WS2;
                    end else if (is_digit) begin
                        st_next.second_num  = acc_val;
                        st_next.ovf         = st_reg.ovf | acc_ovf;
                        st_next.second_seen = 1'b1;
                        st_next.phase       = PH_NUM2;
                    end else begin
                        st_next.err = 1'b1;
                    end
                end
                PH_NUM2: begin
                    if (is_digit) begin
                        st_next.second_num = acc_val;
                        st_next.ovf        = st_reg.ovf | acc_ovf;
                    end else if (is_ws) begin
                        st_next.phase = PH_TRAIL;
                    end else begin
                        st_next.err = 1'b1;
                    end
                end
                PH_TRAIL: begin
                    if (!is_ws) begin
                        st_next.err = 1'b1;
                    end
                end
                default: begin
                    st_next.err = 1'b1;
                end
            endcase
        end
    end

    assign snap      = st_next;
    assign snap_load = beat_en & last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= PARSE_CLEAR;
        end else if (beat_en) begin
            st_reg <= last_byte ? PARSE_CLEAR : st_next;
        end
    end

endmodule

[rtl/hbrp_eval.sv]
// Range evaluation of a finished parse against the file size.
module hbrp_eval
    import hbrp_pkg::*;
(
    input  parse_state_t      snap,
    input  logic [SIZE_W-1:0] total_len,
    output range_result_t     result
);

    logic [NUM_W-1:0]  size_x;
    logic [SIZE_W-1:0] size_m1;
    logic [SIZE_W-1:0] suffix_start;
    logic              second_ok;
    logic              second_big;
    logic              ok;
    logic [SIZE_W-1:0] start_ofs;
    logic [SIZE_W-1:0] end_ofs;

    always_comb begin
        size_x       = {1'b0, total_len};
        size_m1      = total_len - {{(SIZE_W-1){1'b0}}, 1'b1};
        second_big   = snap.second_num >= size_x;
        suffix_start = total_len - snap.second_num[SIZE_W-1:0];
        second_ok    = snap.second_seen
                       && ((snap.phase == PH_NUM2) || (snap.phase == PH_TRAIL));
        ok        = 1'b0;
        start_ofs = '0;
        end_ofs   = '0;
        if (snap.err || snap.ovf || (total_len == '0)) begin
            ok = 1'b0;
        end else if (snap.first_seen) begin
            if (snap.first_num >= size_x) begin
                ok = 1'b0;
            end else if (snap.phase == PH_DASH) begin
                ok        = 1'b1;
                start_ofs = snap.first_num[SIZE_W-1:0];
                end_ofs   = size_m1;
            end else if (second_ok && (snap.second_num >= snap.first_num)) begin
                ok        = 1'b1;
                start_ofs = snap.first_num[SIZE_W-1:0];
                end_ofs   = second_big ? size_m1 : snap.second_num[SIZE_W-1:0];
            end
        end else if (second_ok && (snap.second_num != '0)) begin
            ok        = 1'b1;
            start_ofs = second_big ? '0 : suffix_start;
            end_ofs   = size_m1;
        end
        result.status    = ~ok;
        result.start_ofs = start_ofs;
        result.end_ofs   = end_ofs;
    end

endmodule

[rtl/http_byte_range_parse_top.sv]
// Top level of the HTTP single byte-range header parser.
// Header value bytes stream in on s_ one beat per cycle while s_tready is
// high, the last byte of a value marked by s_tlast; the next value may
// follow at once. The parse state machine folds each byte in as it arrives
// (prefix "bytes=", case-insensitive, optional whitespace, then "a-b", "a-"
// or "-n" with a times-ten accumulate per digit). On the last beat the
// finished state is captured in a snapshot register and evaluated against
// the total length, and the one result beat is registered from it into the
// output register as soon as that register is free, which raises m_tvalid.
// m_tuser is the status: 0 satisfiable, 1 malformed or not satisfiable, in
// which case start and end read zero. The snapshot and output registers
// form a two-entry holding path, so input keeps flowing while a result waits
// for m_tready; s_tready drops only when both are full and m_tready is low.
// The total length is written through cfg_we/cfg_wdata and must only change
// while no value is in flight; it resets to zero, which rejects every range.
module http_byte_range_parse_top
    import hbrp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration: total length of the file in bytes
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    // header bytes
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] value_byte
    input  logic              s_tlast,   // last_byte
    // range results
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [127:0]      m_tdata,   // [62:0] range_start, [125:63] range_end
    output logic              m_tuser    // range_status
);

    logic [SIZE_W-1:0] total_len_reg;

    logic          beat_en;
    logic          snap_load;
    parse_state_t  snap;
    parse_state_t  snap_reg;
    logic          snap_vld_reg;
    range_result_t result;
    range_result_t out_reg;
    logic          out_vld_reg;
    logic          out_free;

    // holding path flow control
    assign out_free = !out_vld_reg || m_tready;
    assign s_tready = !snap_vld_reg || out_free;
    assign beat_en  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_len_reg <= '0;
        end else if (cfg_we) begin
            total_len_reg <= cfg_wdata;
        end
    end

    hbrp_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_en    (beat_en),
        .value_byte (s_tdata),
        .last_byte  (s_tlast),
        .snap_load  (snap_load),
        .snap       (snap)
    );

    // snapshot of the finished parse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_vld_reg <= 1'b0;
        end else if (snap_load) begin
            snap_vld_reg <= 1'b1;
        end else if (out_free) begin
            snap_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_load) begin
            snap_reg <= snap;
        end
    end

    hbrp_eval u_eval (
        .snap      (snap_reg),
        .total_len (total_len_reg),
        .result    (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= snap_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && snap_vld_reg) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {2'b00, out_reg.end_ofs, out_reg.start_ofs};

endmodule
